// ----- design/sepool_pkg.sv -----
// sepool_pkg: shared types, command codes and constants of the sparse edge max pool.
// Used by sepool_maxu and sparse_edge_max_pool. No dependencies.
`timescale 1ns / 1ps

package sepool_pkg;

  // default store geometry
  localparam int DEF_MAX_BATCH        = 4;
  localparam int DEF_MAX_IN_VERTICES  = 256;
  localparam int DEF_MAX_OUT_VERTICES = 64;
  localparam int DEF_MAX_FEATURES     = 64;

  // field widths
  localparam int CMD_W   = 2;
  localparam int BATCH_W = 2;
  localparam int SRC_W   = 8;
  localparam int DST_W   = 6;
  localparam int FEAT_W  = 6;
  localparam int VAL_W   = 16;
  localparam int FC_W    = 7;

  localparam logic [FC_W-1:0] FC_RESET = 7'd64;

  localparam logic signed [VAL_W-1:0] Q_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] Q_MAX = 16'sh7fff;

  // configuration register indexes
  localparam logic REG_FEATURE_COUNT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_READ = 2'd2,
    CMD_INIT = 2'd3
  } cmd_e;

  // operands of one feature step
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] weight;
    logic signed [VAL_W-1:0] feat;
    logic signed [VAL_W-1:0] old;
  } mac_in_t;

  // outcome of one feature step
  typedef struct packed {
    logic                    valid;
    logic                    upd;
    logic signed [VAL_W-1:0] value;
  } mac_out_t;

endpackage

// ----- design/sepool_maxu.sv -----
// sepool_maxu: shared multiply / scale / saturate / max unit, one feature per cycle.
// Two stages: registered product, then saturate and compare. Depends on sepool_pkg.
`timescale 1ns / 1ps

module sepool_maxu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sepool_pkg::mac_in_t in_i,
  output sepool_pkg::mac_out_t out_o
);
  import sepool_pkg::*;

  logic                      valid_q;
  logic signed [2*VAL_W-1:0] prod_q;
  logic signed [VAL_W-1:0]   old_q;
  logic signed [VAL_W-1:0]   sat;
  logic                      fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid) begin
      prod_q <= in_i.weight * in_i.feat;
      old_q  <= in_i.old;
    end
  end

  // arithmetic shift by 8 floors; result fits when bits 31..23 agree
  always_comb begin
    fits = (prod_q[2*VAL_W-1:VAL_W+7] == '0) || (prod_q[2*VAL_W-1:VAL_W+7] == '1);
    if (fits) begin
      sat = prod_q[VAL_W+7:8];
    end else if (prod_q[2*VAL_W-1]) begin
      sat = Q_MIN;
    end else begin
      sat = Q_MAX;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.upd   = valid_q && (sat > old_q);
  assign out_o.value = sat;

endmodule

// ----- design/sparse_edge_max_pool.sv -----
// sparse_edge_max_pool: top level, vertex and pooled stores, sequencer, config port.
// Depends on sepool_pkg and sepool_maxu.
//
//   port group        direction  handshake
//   command word      in         start_i high while busy_o low
//   result word       out        out_valid_o high for one cycle
//   config register   in/out     apb write at psel & penable & pwrite & pready
//
// after accept: load and initialize pass execute back to idle, a read execute and then
// response (result word registered behind it), an edge steps feature_count features
// (capped at MAX_FEATURES, none without work), one feature per cycle through the shared
// multiply/max unit, then a drain; after reset the pooled store is cleared one entry a cycle
// (all MAX_BATCH*MAX_OUT_VERTICES*MAX_FEATURES entries, 16384 by default), busy_o high
// results are never held back: the receiver takes each word in its strobe cycle
`timescale 1ns / 1ps

module sparse_edge_max_pool #(
  parameter int MAX_BATCH        = sepool_pkg::DEF_MAX_BATCH,
  parameter int MAX_IN_VERTICES  = sepool_pkg::DEF_MAX_IN_VERTICES,
  parameter int MAX_OUT_VERTICES = sepool_pkg::DEF_MAX_OUT_VERTICES,
  parameter int MAX_FEATURES     = sepool_pkg::DEF_MAX_FEATURES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [sepool_pkg::CMD_W-1:0]          cmd_i,
  input  logic [sepool_pkg::BATCH_W-1:0]        batch_i,
  input  logic [sepool_pkg::SRC_W-1:0]          src_vertex_i,
  input  logic [sepool_pkg::DST_W-1:0]          dst_vertex_i,
  input  logic [sepool_pkg::FEAT_W-1:0]         feature_i,
  input  logic signed [sepool_pkg::VAL_W-1:0]   value_i,
  output logic                                  out_valid_o,
  output logic signed [sepool_pkg::VAL_W-1:0]   out_value_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import sepool_pkg::*;

  localparam int VSIZE = MAX_BATCH * MAX_IN_VERTICES * MAX_FEATURES;
  localparam int PSIZE = MAX_BATCH * MAX_OUT_VERTICES * MAX_FEATURES;
  localparam int VA_W  = (VSIZE > 1) ? $clog2(VSIZE) : 1;
  localparam int PA_W  = (PSIZE > 1) ? $clog2(PSIZE) : 1;
  localparam int FI_W  = $clog2(MAX_FEATURES + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_EDGE  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  logic [FC_W-1:0] fc_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FEATURE_COUNT);
  assign prdata = (paddr[2] == REG_FEATURE_COUNT) ? 32'(fc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= FC_RESET;
    end else if (cfg_wr) begin
      fc_q <= pwdata[FC_W-1:0];
    end
  end

  // command word capture
  logic                    accept;
  cmd_e                    cmd_in, cmd_q;
  logic                    b_ok, src_ok, dst_ok, f_ok, ok_d, ok_q;
  int                      vbase, pbase;
  logic [VA_W-1:0]         vaddr_d, vaddr_q;
  logic [PA_W-1:0]         paddr_d, paddr_q;
  logic signed [VAL_W-1:0] val_q;
  logic [FI_W-1:0]         n_d, n_q;

  assign accept = start_i && !busy_o;
  assign cmd_in = cmd_e'(cmd_i);

  always_comb begin
    b_ok   = 32'(batch_i) < MAX_BATCH;
    src_ok = 32'(src_vertex_i) < MAX_IN_VERTICES;
    dst_ok = 32'(dst_vertex_i) < MAX_OUT_VERTICES;
    f_ok   = 32'(feature_i) < MAX_FEATURES;
    vbase  = (int'(batch_i) * MAX_IN_VERTICES + int'(src_vertex_i)) * MAX_FEATURES;
    pbase  = (int'(batch_i) * MAX_OUT_VERTICES + int'(dst_vertex_i)) * MAX_FEATURES;
    case (cmd_in)
      CMD_LOAD: begin
        ok_d    = b_ok && src_ok && f_ok;
        vaddr_d = VA_W'(vbase + int'(feature_i));
        paddr_d = PA_W'(pbase);
      end
      CMD_EDGE: begin
        ok_d    = b_ok && src_ok && dst_ok;
        vaddr_d = VA_W'(vbase);
        paddr_d = PA_W'(pbase);
      end
      default: begin
        ok_d    = b_ok && dst_ok && f_ok;
        vaddr_d = VA_W'(vbase);
        paddr_d = PA_W'(pbase + int'(feature_i));
      end
    endcase
    if (32'(fc_q) > MAX_FEATURES) begin
      n_d = FI_W'(MAX_FEATURES);
    end else begin
      n_d = FI_W'(fc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_in;
      ok_q    <= ok_d;
      vaddr_q <= vaddr_d;
      paddr_q <= paddr_d;
      val_q   <= value_i;
      n_q     <= n_d;
    end
  end

  // sequencer
  logic [PA_W-1:0] clr_q;
  logic [FI_W-1:0] f_q;
  logic            rd_v_q;
  logic [FI_W-1:0] idx1_q, idx2_q;
  mac_in_t         mac_in;
  mac_out_t        mac_out;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == PA_W'(PSIZE - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = ST_EXEC;
      ST_EXEC: begin
        case (cmd_q)
          CMD_EDGE: state_d = (ok_q && (n_q != '0)) ? ST_EDGE : ST_IDLE;
          CMD_READ: state_d = ST_RESP;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_EDGE:  if (f_q + 1'b1 == n_q) state_d = ST_DRAIN;
      ST_DRAIN: if (!rd_v_q && !mac_out.valid) state_d = ST_IDLE;
      ST_RESP:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      f_q     <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == ST_EDGE);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_EDGE) begin
        f_q <= f_q + 1'b1;
      end else begin
        f_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= f_q;
    if (rd_v_q) begin
      idx2_q <= idx1_q;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // stores
  logic signed [VAL_W-1:0] vmem [VSIZE];
  logic signed [VAL_W-1:0] pmem [PSIZE];
  logic signed [VAL_W-1:0] vrd_q, prd_q;
  logic [VA_W-1:0]         vm_ra;
  logic [PA_W-1:0]         pm_ra, pm_wa;
  logic                    vm_we, pm_we;
  logic signed [VAL_W-1:0] pm_wd;

  assign vm_we = (state_q == ST_EXEC) && (cmd_q == CMD_LOAD) && ok_q;
  assign vm_ra = vaddr_q + VA_W'(f_q);
  assign pm_ra = (state_q == ST_EDGE) ? (paddr_q + PA_W'(f_q)) : paddr_q;

  always_comb begin
    pm_we = 1'b0;
    pm_wa = paddr_q;
    pm_wd = val_q;
    if (state_q == ST_CLEAR) begin
      pm_we = 1'b1;
      pm_wa = clr_q;
      pm_wd = Q_MIN;
    end else if ((state_q == ST_EXEC) && (cmd_q == CMD_INIT) && ok_q) begin
      pm_we = 1'b1;
    end else if (mac_out.upd) begin
      pm_we = 1'b1;
      pm_wa = paddr_q + PA_W'(idx2_q);
      pm_wd = mac_out.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vmem[vaddr_q] <= val_q;
    end
    vrd_q <= vmem[vm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pmem[pm_wa] <= pm_wd;
    end
    prd_q <= pmem[pm_ra];
  end

  // one feature step per cycle through the shared unit
  assign mac_in.valid  = rd_v_q;
  assign mac_in.weight = val_q;
  assign mac_in.feat   = vrd_q;
  assign mac_in.old    = prd_q;

  sepool_maxu u_maxu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (mac_in),
    .out_o  (mac_out)
  );

  // result word
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (state_q == ST_RESP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP) begin
      out_value_q <= ok_q ? prd_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;

endmodule
